@@ rtl/cstrip_pkg.sv @@
// ----------------------------------------------------------------------------
// Comment stripper package
// Character codes, scan modes and the result beat type that are used by the
// stripper core.
// ----------------------------------------------------------------------------
package cstrip_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;

  // Depth of the result queue between the scanner and the output port.
  localparam int unsigned QDEPTH = 3;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
  localparam int unsigned QIDX_W = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    MODE_NORMAL    = 3'd0,
    MODE_HELD      = 3'd1,
    MODE_LINE      = 3'd2,
    MODE_BLOCK     = 3'd3,
    MODE_BLOCKSTAR = 3'd4,
    MODE_STRING    = 3'd5
  } mode_t;

  // One result beat: character, character-present flag and end-of-text flag.
  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       last;
  } result_t;

  localparam result_t RESULT_NONE = '{ch: 8'h00, has: 1'b0, last: 1'b0};

endpackage

@@ rtl/comment_stripper_core.sv @@
// ----------------------------------------------------------------------------
// Comment stripper core
// Streams source text and drops line and block comments, keeping newlines and
// leaving double-quoted strings untouched.
// ----------------------------------------------------------------------------
// The core takes one source byte per beat and normally delivers one result
// beat per input beat, so a byte can be accepted in every cycle while the
// output keeps taking results. A slash in plain text is held back for one
// byte; if that next byte does not open a comment the held slash and the
// byte leave together as two result beats; the input stalls until one drains.
// Bytes inside comments produce no result at all, except newlines, which are kept.
// A beat with in_tlast ends the text: a still held slash is flushed, and if
// nothing else came out of that byte an empty marker (out_tuser low, data
// zero) is sent; the last result beat of the text carries out_tlast. After
// that the scanner starts over in plain text. All scanning is combinational
// at acceptance; results wait in a three-entry queue whose head drives
// the output port, and in_tready depends only on the queue fill register.
module comment_stripper_core (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_end
  // Result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] out_has_byte
  output logic       out_tlast   // out_end
);
  import cstrip_pkg::*;

  mode_t                 mode_r, mode_nxt, mode_scan;
  logic                  prev_bs_r, prev_bs_nxt;
  result_t               q_r [QDEPTH];
  result_t               q_nxt [QDEPTH];
  logic [QCNT_W-1:0]     occ_r, occ_nxt, occ_pop;
  result_t               res0, res1;
  logic [1:0]            n_res;
  logic                  in_acc, out_acc;

  assign in_acc  = in_tvalid & in_tready;
  assign out_acc = out_tvalid & out_tready;

  // Room for two results is guaranteed while at most one beat is waiting.
  assign in_tready  = (occ_r <= QCNT_W'(1));
  assign out_tvalid = (occ_r != '0);
  assign out_tdata  = q_r[0].ch;
  assign out_tuser  = q_r[0].has;
  assign out_tlast  = q_r[0].last;

  // Next scan mode for the current byte, before end-of-text handling.
  always_comb begin
    mode_scan = mode_r;
    case (mode_r)
      MODE_HELD: begin
        if (in_tdata == CH_SLASH) begin
          mode_scan = MODE_LINE;
        end else if (in_tdata == CH_STAR) begin
          mode_scan = MODE_BLOCK;
        end else begin
          mode_scan = (in_tdata == CH_QUOTE) ? MODE_STRING : MODE_NORMAL;
        end
      end
      MODE_LINE: begin
        if (in_tdata == CH_NL) begin
          mode_scan = MODE_NORMAL;
        end
      end
      MODE_BLOCK, MODE_BLOCKSTAR: begin
        // The star of the opener never counts toward the closing pair.
        if (mode_r == MODE_BLOCKSTAR && in_tdata == CH_SLASH) begin
          mode_scan = MODE_NORMAL;
        end else if (in_tdata == CH_STAR) begin
          mode_scan = MODE_BLOCKSTAR;
        end else begin
          mode_scan = MODE_BLOCK;
        end
      end
      MODE_STRING: begin
        // Single-backslash rule: a quote right after a backslash stays inside.
        if (in_tdata == CH_QUOTE && !prev_bs_r) begin
          mode_scan = MODE_NORMAL;
        end
      end
      default: begin
        if (in_tdata == CH_SLASH) begin
          mode_scan = MODE_HELD;
        end else begin
          mode_scan = (in_tdata == CH_QUOTE) ? MODE_STRING : MODE_NORMAL;
        end
      end
    endcase
  end

  always_comb begin
    mode_nxt    = mode_r;
    prev_bs_nxt = prev_bs_r;
    if (in_acc) begin
      // The end of the text drops any open comment or string.
      mode_nxt    = in_tlast ? MODE_NORMAL : mode_scan;
      prev_bs_nxt = in_tlast ? 1'b0 : (in_tdata == CH_BSLASH);
    end
  end

  // Result beats caused by the current byte.
  always_comb begin
    res0  = RESULT_NONE;
    res1  = RESULT_NONE;
    n_res = 2'd0;
    case (mode_r)
      MODE_HELD: begin
        if (in_tdata != CH_SLASH && in_tdata != CH_STAR) begin
          res0  = '{ch: CH_SLASH, has: 1'b1, last: 1'b0};
          res1  = '{ch: in_tdata, has: 1'b1, last: 1'b0};
          n_res = 2'd2;
        end
      end
      MODE_LINE, MODE_BLOCK, MODE_BLOCKSTAR: begin
        if (in_tdata == CH_NL) begin
          res0  = '{ch: in_tdata, has: 1'b1, last: 1'b0};
          n_res = 2'd1;
        end
      end
      MODE_STRING: begin
        res0  = '{ch: in_tdata, has: 1'b1, last: 1'b0};
        n_res = 2'd1;
      end
      default: begin
        if (in_tdata != CH_SLASH) begin
          res0  = '{ch: in_tdata, has: 1'b1, last: 1'b0};
          n_res = 2'd1;
        end
      end
    endcase

    if (in_tlast) begin
      // A slash is only newly held when nothing else came out of this byte.
      if (mode_scan == MODE_HELD) begin
        res0  = '{ch: CH_SLASH, has: 1'b1, last: 1'b0};
        n_res = 2'd1;
      end else if (n_res == 2'd0) begin
        res0  = RESULT_NONE;
        n_res = 2'd1;
      end
      if (n_res == 2'd2) begin
        res1.last = 1'b1;
      end else begin
        res0.last = 1'b1;
      end
    end
  end

  // Result queue: pop at the head, then append behind what remains.
  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    occ_pop = occ_r - QCNT_W'(out_acc);
    if (out_acc) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    occ_nxt = occ_pop;
    if (in_acc) begin
      if (n_res != 2'd0) begin
        q_nxt[occ_pop[QIDX_W-1:0]] = res0;
      end
      if (n_res == 2'd2) begin
        q_nxt[occ_pop[QIDX_W-1:0] + QIDX_W'(1)] = res1;
      end
      occ_nxt = occ_pop + QCNT_W'(n_res);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NORMAL;
      prev_bs_r <= 1'b0;
      occ_r     <= '0;
    end else begin
      mode_r    <= mode_nxt;
      prev_bs_r <= prev_bs_nxt;
      occ_r     <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

@@ rtl/cstrip_chk.sv @@
// ----------------------------------------------------------------------------
// Comment stripper port checker
// Watches the core ports and flags source and result beats that break rules.
// ----------------------------------------------------------------------------
module cstrip_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat shown right after reset");

  // An empty marker only closes a text.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("empty marker without end flag");

  // An empty marker carries zero data.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 8'h00)
    else $error("empty marker with nonzero data");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result beat changed");

  // A source beat that waits for the core keeps its byte and end flag.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata)
      && $stable(in_tlast))
    else $error("stalled source beat changed");

endmodule

bind comment_stripper_core cstrip_chk u_cstrip_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
